[rtl/spp_pkg.sv]
// Shared types and constants for the spatial pixel predictor.
// No dependencies; every other file but spp_ram refers to this package by scoped names.
package spp_pkg;

  localparam int SAMPLE_BITS = 9;
  localparam int CFG_BITS    = 13;
  localparam int CFG_IDX_BITS = 2;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_BITS-1:0] RST_IMAGE_WIDTH  = 13'd64;
  localparam logic [CFG_BITS-1:0] RST_IMAGE_HEIGHT = 13'd64;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [SAMPLE_BITS-1:0] RESID_BIAS = 9'h100;

  // Position class of a pixel, decided in the front end
  typedef enum logic [1:0] {
    CLS_FIRST    = 2'd0,
    CLS_TOP_ROW  = 2'd1,
    CLS_LEFT_COL = 2'd2,
    CLS_MAIN     = 2'd3
  } spp_cls_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    spp_cls_e               cls;
    logic                   last;
  } spp_pend_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] top;
    spp_cls_e               cls;
    logic                   last;
  } spp_item_t;

endpackage

[rtl/spatial_pixel_predictor.sv]
// Top level of the spatial pixel predictor: front end, queue, back end.
// Depends on spp_pkg, spp_ram, spp_front, spp_queue and spp_back.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------
//  input    | in        | in_valid_i/in_stall_o | sample_i[8:0]
//  output   | out       | out_valid_o/out_stall_i | residual_o[8:0], frame_end_o
//  config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i[1:0], cfg_data_i
//
// One sample per cycle sustained while out_stall_i is low; each residual goes
// through the pending stage (with line-store read), queue and output register.
// The line store is read and written once per sample on one port pair.
// Reset clears counters, sizes (64 x 64) and the handshake state; the line
// store is not cleared. Output stalls fill the two-entry queue, then the
// pending stage, before in_stall_o rises. Config writes are always taken.
module spatial_pixel_predictor #(
  parameter int MAX_WIDTH  = spp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = spp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spp_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [spp_pkg::CFG_BITS-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [spp_pkg::SAMPLE_BITS-1:0]  sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [spp_pkg::SAMPLE_BITS-1:0]  residual_o,
  output logic                             frame_end_o
);

  logic               fe_valid, q_ready, q_valid, pop;
  spp_pkg::spp_item_t fe_item, q_item;

  assign cfg_ready_o = 1'b1;

  spp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .item_valid_o (fe_valid),
    .item_ready_i (q_ready),
    .item_o       (fe_item)
  );

  spp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .item_i  (fe_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  spp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .residual_o   (residual_o),
    .frame_end_o  (frame_end_o)
  );

  // a stalled result must not be overwritten by the back end
  a_no_pop_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !pop)
    else $error("back end popped while output stalled");

  // a new transfer never replaces a pending item that could not move on
  a_pend_not_lost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!fe_valid || q_ready))
    else $error("pending item overwritten");

  // a result is only registered from a valid queue head
  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

[rtl/spp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read of the address being written returns the old contents. No dependencies.
module spp_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/spp_front.sv]
// Front end: configuration registers, raster position counters, line store
// and pixel classification. Uses spp_pkg and spp_ram.
module spp_front #(
  parameter int MAX_WIDTH  = spp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = spp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [spp_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [spp_pkg::CFG_BITS-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [spp_pkg::SAMPLE_BITS-1:0]   sample_i,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output spp_pkg::spp_item_t                item_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int MW  = (CW > RW) ? CW : RW;
  localparam int WW  = ((MW > spp_pkg::CFG_BITS) ? MW : spp_pkg::CFG_BITS) + 1;
  localparam logic [WW-1:0] MaxW = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] MaxH = WW'(MAX_HEIGHT);

  logic [spp_pkg::CFG_BITS-1:0] width_q, height_q;
  logic [CW-1:0]                col_q, col_d;
  logic [RW-1:0]                row_q, row_d;
  logic                         pend_valid_q, pend_valid_d;
  spp_pkg::spp_pend_t           pend_q, pend_d;

  logic [WW-1:0] eff_w, eff_h, col_ext, row_ext, col_sat, row_sat;
  logic [CW-1:0] col_idx;
  logic [RW-1:0] row_idx;
  logic          last_col, last_row, accept;
  spp_pkg::spp_cls_e cls;
  logic [spp_pkg::SAMPLE_BITS-1:0] top;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= spp_pkg::RST_IMAGE_WIDTH;
      height_q <= spp_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == spp_pkg::REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == spp_pkg::REG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (WW'(width_q) > MaxW) begin
      eff_w = MaxW;
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = WW'(1);
    end else if (WW'(height_q) > MaxH) begin
      eff_h = MaxH;
    end else begin
      eff_h = WW'(height_q);
    end
  end

  // counters kept across a size change saturate to the last column / row
  assign col_ext  = WW'(col_q);
  assign row_ext  = WW'(row_q);
  assign col_sat  = (col_ext >= eff_w) ? eff_w - WW'(1) : col_ext;
  assign row_sat  = (row_ext >= eff_h) ? eff_h - WW'(1) : row_ext;
  assign col_idx  = col_sat[CW-1:0];
  assign row_idx  = row_sat[RW-1:0];
  assign last_col = (col_sat == eff_w - WW'(1));
  assign last_row = (row_sat == eff_h - WW'(1));

  always_comb begin
    if (col_idx == '0 && row_idx == '0) begin
      cls = spp_pkg::CLS_FIRST;
    end else if (row_idx == '0) begin
      cls = spp_pkg::CLS_TOP_ROW;
    end else if (col_idx == '0) begin
      cls = spp_pkg::CLS_LEFT_COL;
    end else begin
      cls = spp_pkg::CLS_MAIN;
    end
  end

  // a held pending item keeps the RAM read data stable until it moves on
  assign in_stall_o = pend_valid_q & ~item_ready_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (item_ready_i) begin
      pend_valid_d = 1'b0;
    end
    if (accept) begin
      pend_valid_d  = 1'b1;
      pend_d.sample = sample_i;
      pend_d.cls    = cls;
      pend_d.last   = last_col & last_row;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_idx + RW'(1);
      end else begin
        col_d = col_idx + CW'(1);
        row_d = row_idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  spp_ram #(
    .WIDTH (spp_pkg::SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_idx),
    .wdata_i (sample_i),
    .re_i    (accept),
    .raddr_i (col_idx),
    .rdata_o (top)
  );

  assign item_valid_o  = pend_valid_q;
  assign item_o.sample = pend_q.sample;
  assign item_o.top    = top;
  assign item_o.cls    = pend_q.cls;
  assign item_o.last   = pend_q.last;

endmodule

[rtl/spp_queue.sv]
// Two-entry queue of classified pixels between front and back end.
// Uses spp_pkg for the item type.
module spp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  spp_pkg::spp_item_t item_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               pop_i,
  output spp_pkg::spp_item_t item_o
);

  spp_pkg::spp_item_t slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;
  assign item_o  = slot_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

[rtl/spp_back.sv]
// Back end: neighbour prediction, residual and the output register.
// Holds the left and upper-left samples. Uses spp_pkg.
module spp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  input  spp_pkg::spp_item_t              item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [spp_pkg::SAMPLE_BITS-1:0] residual_o,
  output logic                            frame_end_o
);

  localparam int SB = spp_pkg::SAMPLE_BITS;

  logic [SB-1:0]   left_q, ul_q;
  logic            out_valid_q;
  logic [SB-1:0]   residual_q, residual_d;
  logic            frame_end_q;
  logic [SB-1:0]   t, pred, blend;
  logic [SB+2:0]   wsum;

  assign t     = item_i.top;
  assign pop_o = item_valid_i & (~out_valid_q | ~out_stall_i);

  // 3*top + 3*left + 2*upper-left fits in SB+3 bits
  assign wsum  = ({3'b0, t} << 1) + {3'b0, t} + ({3'b0, left_q} << 1) + {3'b0, left_q}
               + ({3'b0, ul_q} << 1);
  assign blend = wsum[SB+2:3];

  always_comb begin
    case (item_i.cls)
      spp_pkg::CLS_TOP_ROW:  pred = left_q;
      spp_pkg::CLS_LEFT_COL: pred = t;
      spp_pkg::CLS_MAIN: begin
        if (ul_q == t) begin
          pred = left_q;
        end else if (ul_q == left_q) begin
          pred = t;
        end else if (t == left_q) begin
          pred = ul_q;
        end else begin
          pred = blend;
        end
      end
      default:               pred = '0;
    endcase
    if (item_i.cls == spp_pkg::CLS_FIRST) begin
      residual_d = item_i.sample;
    end else begin
      residual_d = item_i.sample - pred + spp_pkg::RESID_BIAS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      residual_q  <= residual_d;
      frame_end_q <= item_i.last;
      left_q      <= item_i.sample;
      ul_q        <= t;
    end
  end

  assign out_valid_o = out_valid_q;
  assign residual_o  = residual_q;
  assign frame_end_o = frame_end_q;

endmodule
